// File: sv/ccr_pkg.sv
// shared widths, constants and payload types of the circle contact resolver
package ccr_pkg;

    localparam int VEC_W      = 64;
    localparam int HALF_W     = 32;
    localparam int RAD_W      = 32;
    localparam int IM_W       = 32;
    localparam int BNC_W      = 17;
    localparam int MASK_W     = 2;
    localparam int CFG_W      = 32;
    localparam int NRM_W      = 16;
    localparam int DEPTH_W    = 32;

    // distance root, body share and normal quotient widths
    localparam int DIST_W     = 33;
    localparam int SHARE_FRAC = 24;
    localparam int SHARE_W    = SHARE_FRAC + 1;
    localparam int NRM_FRAC   = 14;
    localparam int NQ_W       = NRM_FRAC + 1;
    localparam int NNUM_W     = DIST_W + NRM_FRAC + 1;

    localparam logic [CFG_W-1:0] CFG_NORMAL_RST = 32'h4000_0000;

    typedef struct packed {
        logic [VEC_W-1:0]  pos_a;
        logic [VEC_W-1:0]  pos_b;
        logic [VEC_W-1:0]  vel_a;
        logic [VEC_W-1:0]  vel_b;
        logic [RAD_W-1:0]  radius_a;
        logic [RAD_W-1:0]  radius_b;
        logic [IM_W-1:0]   inv_mass_a;
        logic [IM_W-1:0]   inv_mass_b;
        logic [BNC_W-1:0]  bounce_a;
        logic [BNC_W-1:0]  bounce_b;
        logic [MASK_W-1:0] dynamic_mask;
    } t_pair;

    typedef struct packed {
        logic                      contact_hit;
        logic                      impulse_applied;
        logic signed [DEPTH_W-1:0] depth;
        logic [CFG_W-1:0]          contact_normal;
        logic [VEC_W-1:0]          new_pos_a;
        logic [VEC_W-1:0]          new_pos_b;
        logic [VEC_W-1:0]          new_vel_a;
        logic [VEC_W-1:0]          new_vel_b;
    } t_result;

endpackage

// File: sv/ccr_ifs.sv
// valid/ready channel interfaces for circle pairs and contact results
interface ccr_pair_if import ccr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VEC_W-1:0]  pos_a;
    logic [VEC_W-1:0]  pos_b;
    logic [VEC_W-1:0]  vel_a;
    logic [VEC_W-1:0]  vel_b;
    logic [RAD_W-1:0]  radius_a;
    logic [RAD_W-1:0]  radius_b;
    logic [IM_W-1:0]   inv_mass_a;
    logic [IM_W-1:0]   inv_mass_b;
    logic [BNC_W-1:0]  bounce_a;
    logic [BNC_W-1:0]  bounce_b;
    logic [MASK_W-1:0] dynamic_mask;

    modport source (output valid, pos_a, pos_b, vel_a, vel_b, radius_a, radius_b,
                    inv_mass_a, inv_mass_b, bounce_a, bounce_b, dynamic_mask,
                    input ready);
    modport sink (input valid, pos_a, pos_b, vel_a, vel_b, radius_a, radius_b,
                  inv_mass_a, inv_mass_b, bounce_a, bounce_b, dynamic_mask,
                  output ready);
endinterface

interface ccr_result_if import ccr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      contact_hit;
    logic                      impulse_applied;
    logic signed [DEPTH_W-1:0] depth;
    logic [CFG_W-1:0]          contact_normal;
    logic [VEC_W-1:0]          new_pos_a;
    logic [VEC_W-1:0]          new_pos_b;
    logic [VEC_W-1:0]          new_vel_a;
    logic [VEC_W-1:0]          new_vel_b;

    modport source (output valid, contact_hit, impulse_applied, depth, contact_normal,
                    new_pos_a, new_pos_b, new_vel_a, new_vel_b, input ready);
    modport sink (input valid, contact_hit, impulse_applied, depth, contact_normal,
                  new_pos_a, new_pos_b, new_vel_a, new_vel_b, output ready);
endinterface

// File: sv/ccr_delay.sv
// register delay line carrying a payload word and its valid bit
module ccr_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_data [N];
    logic [N-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < N; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int k = 1; k < N; k++) begin
                r_data[k] <= r_data[k-1];
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_data  = r_data[N-1];
endmodule

// File: sv/ccr_div.sv
// pipelined restoring divider, one quotient bit per stage
module ccr_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 33,
    parameter int Q_W   = 15
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quot
);
    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [CW-1:0]    r_rem  [Q_W];
    logic [DEN_W-1:0] r_den  [Q_W];
    logic [Q_W-1:0]   r_quot [Q_W];
    logic [CW-1:0]    n_rem  [Q_W];
    logic [Q_W-1:0]   n_quot [Q_W];
    logic [CW-1:0]    w_rem_in [Q_W];
    logic [CW-1:0]    w_trial  [Q_W];
    logic [DEN_W-1:0] w_den_in [Q_W];
    logic [Q_W-1:0]   w_q_in   [Q_W];

    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            if (k == 0) begin
                w_rem_in[k] = CW'(i_num);
                w_den_in[k] = i_den;
                w_q_in[k]   = '0;
            end else begin
                w_rem_in[k] = r_rem[k-1];
                w_den_in[k] = r_den[k-1];
                w_q_in[k]   = r_quot[k-1];
            end
            w_trial[k] = CW'(w_den_in[k]) << (Q_W - 1 - k);
            if (w_rem_in[k] >= w_trial[k]) begin
                n_rem[k]  = w_rem_in[k] - w_trial[k];
                n_quot[k] = w_q_in[k] | (Q_W'(1) << (Q_W - 1 - k));
            end else begin
                n_rem[k]  = w_rem_in[k];
                n_quot[k] = w_q_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Q_W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= w_den_in[k];
                r_quot[k] <= n_quot[k];
            end
        end
    end

    assign o_quot = r_quot[Q_W-1];
endmodule

// File: sv/ccr_sqrt.sv
// pipelined integer square root, one root bit per stage
module ccr_sqrt #(
    parameter int ROOT_W = 33
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic [ROOT_W-1:0]     o_root
);
    localparam int IN_W = 2 * ROOT_W;
    localparam int RW   = ROOT_W + 3;

    logic [IN_W-1:0]   r_s    [ROOT_W];
    logic [RW-1:0]     r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [IN_W-1:0]   w_s_in    [ROOT_W];
    logic [RW-1:0]     w_rem_in  [ROOT_W];
    logic [ROOT_W-1:0] w_root_in [ROOT_W];
    logic [RW-1:0]     w_cur     [ROOT_W];
    logic [RW-1:0]     w_trial   [ROOT_W];
    logic [RW-1:0]     n_rem     [ROOT_W];
    logic [ROOT_W-1:0] n_root    [ROOT_W];

    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                w_s_in[k]    = i_rad;
                w_rem_in[k]  = '0;
                w_root_in[k] = '0;
            end else begin
                w_s_in[k]    = r_s[k-1];
                w_rem_in[k]  = r_rem[k-1];
                w_root_in[k] = r_root[k-1];
            end
            // bring down the next bit pair and try root*4+1
            w_cur[k]   = (w_rem_in[k] << 2) | RW'(w_s_in[k][IN_W-1 -: 2]);
            w_trial[k] = (RW'(w_root_in[k]) << 2) | RW'(1);
            if (w_cur[k] >= w_trial[k]) begin
                n_rem[k]  = w_cur[k] - w_trial[k];
                n_root[k] = {w_root_in[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = w_cur[k];
                n_root[k] = {w_root_in[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_s[k]    <= w_s_in[k] << 2;
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
endmodule

// File: sv/ccr_skid.sv
// two-entry output buffer that parts the pipeline from the result sink
module ccr_skid #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_space,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_slot [2];
    logic [1:0]   r_cnt;
    logic [1:0]   n_cnt;
    logic         w_pop;

    assign w_pop   = (r_cnt != 2'd0) && i_ready;
    assign n_cnt   = r_cnt + 2'(i_push) - 2'(w_pop);
    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == 2'd2) begin
                r_slot[0] <= r_slot[1];
            end else if (i_push) begin
                r_slot[0] <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_slot[0] <= i_data;
            end else begin
                r_slot[1] <= i_data;
            end
        end
    end
endmodule

// File: sv/circle_contact_resolver.sv
// top level: pipelined impulse response for one pair of 2D circles
//
// One pair is taken per clock while the output buffer has room, and
// each pair gives exactly one result, in order. A pair passes the distance
// square root (33 stages, one root bit each) followed by the normal
// dividers (15 stages, one quotient bit each); the body share dividers
// (25 stages) run beside the root. Every stage holds a valid bit and the
// whole pipe advances together while the two-entry output buffer has
// room, so a stalled sink holds everything without loss; pairs keep
// streaming in while a single result waits. The coincident normal register
// is used as written when the two centres coincide; write it only while
// no pair is in flight.
module circle_contact_resolver import ccr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    ccr_pair_if.sink         i_pair,
    ccr_result_if.source     o_result
);
    localparam int PAIR_W    = $bits(t_pair);
    localparam int RES_W     = $bits(t_result);
    localparam int SQ_W      = 2 * DIST_W;
    localparam int SHARE_DLY = DIST_W - SHARE_W;
    localparam int SNUM_W    = IM_W + SHARE_FRAC;

    // context carried from the root onward; later fields fill in per stage
    typedef struct packed {
        t_pair               pair;
        logic [DIST_W-1:0]   dlen;
        logic [SHARE_W-1:0]  fa;
        logic [SHARE_W-1:0]  fb;
        logic                hit;
        logic                zero;
        logic                has_mass;
        logic                sx;
        logic                sy;
        logic [30:0]         dep;
        logic signed [15:0]  nx;
        logic signed [15:0]  ny;
        logic [30:0]         qa;
        logic [30:0]         qb;
        logic signed [47:0]  pxa;
        logic signed [47:0]  pya;
        logic signed [47:0]  pxb;
        logic signed [47:0]  pyb;
        logic signed [48:0]  vpx;
        logic signed [48:0]  vpy;
        logic [VEC_W-1:0]    npa;
        logic [VEC_W-1:0]    npb;
        logic                approach;
        logic [35:0]         m;
        logic [53:0]         wprod;
        logic [63:0]         gaprod;
        logic [63:0]         gbprod;
        logic signed [56:0]  vxa;
        logic signed [56:0]  vya;
        logic signed [56:0]  vxb;
        logic signed [56:0]  vyb;
    } t_ctx;

    localparam int CTX_W = $bits(t_ctx);

    function automatic logic signed [32:0] diff33(input logic [31:0] a, input logic [31:0] b);
        return $signed({a[31], a}) - $signed({b[31], b});
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // divide by 2^14, halves away from zero
    function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
        logic [63:0] mg;
        mg = v[63] ? 64'(-v) : 64'(v);
        mg = (mg + 64'd8192) >> NRM_FRAC;
        return v[63] ? -$signed(mg) : $signed(mg);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [63:0] sx64(input logic [31:0] v);
        return 64'($signed(v));
    endfunction

    logic             w_en;
    logic             w_space;
    logic [CFG_W-1:0] r_cfg;
    t_pair            w_in;

    // coincident normal register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_NORMAL_RST;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // the whole pipe moves while the output buffer can take one more
    assign w_en         = w_space;
    assign i_pair.ready = w_en;

    assign w_in.pos_a        = i_pair.pos_a;
    assign w_in.pos_b        = i_pair.pos_b;
    assign w_in.vel_a        = i_pair.vel_a;
    assign w_in.vel_b        = i_pair.vel_b;
    assign w_in.radius_a     = i_pair.radius_a;
    assign w_in.radius_b     = i_pair.radius_b;
    assign w_in.inv_mass_a   = i_pair.inv_mass_a;
    assign w_in.inv_mass_b   = i_pair.inv_mass_b;
    assign w_in.bounce_a     = i_pair.bounce_a;
    assign w_in.bounce_b     = i_pair.bounce_b;
    assign w_in.dynamic_mask = i_pair.dynamic_mask;

    // ---------------- front: input register, squares, sum
    logic            r_v1, r_v2, r_v3;
    t_pair           r_p1, r_p2, r_p3;
    logic [SQ_W-1:0] r_sqx, r_sqy, r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_pair.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1  <= w_in;
            r_p2  <= r_p1;
            r_sqx <= SQ_W'(mag33(diff33(r_p1.pos_a[63:32], r_p1.pos_b[63:32])))
                   * SQ_W'(mag33(diff33(r_p1.pos_a[63:32], r_p1.pos_b[63:32])));
            r_sqy <= SQ_W'(mag33(diff33(r_p1.pos_a[31:0], r_p1.pos_b[31:0])))
                   * SQ_W'(mag33(diff33(r_p1.pos_a[31:0], r_p1.pos_b[31:0])));
            r_p3  <= r_p2;
            r_sq  <= r_sqx + r_sqy;
        end
    end

    // ---------------- distance root beside the body share dividers
    logic [DIST_W-1:0]  w_dist;
    logic               w_va, w_vb;
    logic [PAIR_W-1:0]  w_pa, w_pb;
    t_pair              w_pa_s, w_pb_s;
    logic [SHARE_W-1:0] w_fa, w_fb;
    logic [DIST_W-1:0]  w_tot;

    ccr_sqrt #(.ROOT_W(DIST_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_sq),
        .o_root (w_dist)
    );

    ccr_delay #(.W(PAIR_W), .N(SHARE_DLY)) u_dly_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_data  (r_p3),
        .o_valid (w_va),
        .o_data  (w_pa)
    );

    assign w_pa_s = w_pa;
    assign w_tot  = DIST_W'(w_pa_s.inv_mass_a) + DIST_W'(w_pa_s.inv_mass_b);

    // share = inv_mass * 2^24 / total
    ccr_div #(.NUM_W(SNUM_W), .DEN_W(DIST_W), .Q_W(SHARE_W)) u_div_fa (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  ({w_pa_s.inv_mass_a, SHARE_FRAC'(0)}),
        .i_den  (w_tot),
        .o_quot (w_fa)
    );

    ccr_div #(.NUM_W(SNUM_W), .DEN_W(DIST_W), .Q_W(SHARE_W)) u_div_fb (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  ({w_pa_s.inv_mass_b, SHARE_FRAC'(0)}),
        .i_den  (w_tot),
        .o_quot (w_fb)
    );

    ccr_delay #(.W(PAIR_W), .N(SHARE_W)) u_dly_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_va),
        .i_data  (w_pa),
        .o_valid (w_vb),
        .o_data  (w_pb)
    );

    assign w_pb_s = w_pb;

    // ---------------- P1: overlap test, depth, normal numerators
    t_ctx              n_c1, r_c1;
    logic              r_vc1;
    logic [NNUM_W-1:0] n_numx, n_numy, r_numx, r_numy;
    logic signed [32:0] w_dx, w_dy;
    logic [DIST_W-1:0]  w_rsum, w_dep33;

    always_comb begin
        n_c1      = '0;
        n_c1.pair = w_pb_s;
        n_c1.dlen = w_dist;
        n_c1.fa   = w_fa;
        n_c1.fb   = w_fb;
        w_dx      = diff33(w_pb_s.pos_a[63:32], w_pb_s.pos_b[63:32]);
        w_dy      = diff33(w_pb_s.pos_a[31:0], w_pb_s.pos_b[31:0]);
        w_rsum    = DIST_W'(w_pb_s.radius_a) + DIST_W'(w_pb_s.radius_b);
        w_dep33   = w_rsum - w_dist;
        n_c1.hit  = (w_pb_s.dynamic_mask != '0) && (w_dist <= w_rsum);
        // very deep overlap saturates, and the saturated depth drives separation
        n_c1.dep  = (w_dep33 > DIST_W'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : w_dep33[30:0];
        n_c1.zero = (w_dist == '0);
        n_c1.has_mass = ((DIST_W'(w_pb_s.inv_mass_a) + DIST_W'(w_pb_s.inv_mass_b)) != '0);
        n_c1.sx   = w_dx[32];
        n_c1.sy   = w_dy[32];
        // |d| * 2^14 + dist/2, rounds the quotient half up
        n_numx    = {1'b0, mag33(w_dx), NRM_FRAC'(0)} + NNUM_W'(w_dist >> 1);
        n_numy    = {1'b0, mag33(w_dy), NRM_FRAC'(0)} + NNUM_W'(w_dist >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc1 <= 1'b0;
        end else if (w_en) begin
            r_vc1 <= w_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1   <= n_c1;
            r_numx <= n_numx;
            r_numy <= n_numy;
        end
    end

    // ---------------- normal dividers beside the context delay
    logic [NQ_W-1:0]  w_qx, w_qy;
    logic             w_vc1d;
    logic [CTX_W-1:0] w_c1d;

    ccr_div #(.NUM_W(NNUM_W), .DEN_W(DIST_W), .Q_W(NQ_W)) u_div_nx (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_numx),
        .i_den  (r_c1.dlen),
        .o_quot (w_qx)
    );

    ccr_div #(.NUM_W(NNUM_W), .DEN_W(DIST_W), .Q_W(NQ_W)) u_div_ny (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_numy),
        .i_den  (r_c1.dlen),
        .o_quot (w_qy)
    );

    ccr_delay #(.W(CTX_W), .N(NQ_W)) u_dly_nrm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vc1),
        .i_data  (r_c1),
        .o_valid (w_vc1d),
        .o_data  (w_c1d)
    );

    // ---------------- P2..P7 arithmetic tail
    t_ctx n_c2, n_c3, n_c4, n_c5, n_c6, n_c7;
    t_ctx r_c2, r_c3, r_c4, r_c5, r_c6, r_c7;
    logic r_pv2, r_pv3, r_pv4, r_pv5, r_pv6, r_pv7;
    logic signed [49:0] w_vn;
    logic signed [50:0] w_nvn;
    logic [16:0]        w_e;
    logic [38:0]        w_w;
    logic [39:0]        w_ga, w_gb;

    // P2: signed normal (or the register for coincident centres), position shares
    always_comb begin
        n_c2 = w_c1d;
        if (n_c2.zero) begin
            n_c2.nx = $signed(r_cfg[31:16]);
            n_c2.ny = $signed(r_cfg[15:0]);
        end else begin
            n_c2.nx = n_c2.sx ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
            n_c2.ny = n_c2.sy ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
        end
        n_c2.qa = 31'((56'(n_c2.dep) * 56'(n_c2.fa)) >> SHARE_FRAC);
        n_c2.qb = 31'((56'(n_c2.dep) * 56'(n_c2.fb)) >> SHARE_FRAC);
    end

    // P3: shift products and relative velocity along the normal
    always_comb begin
        n_c3     = r_c2;
        n_c3.pxa = r_c2.nx * $signed({1'b0, r_c2.qa});
        n_c3.pya = r_c2.ny * $signed({1'b0, r_c2.qa});
        n_c3.pxb = r_c2.nx * $signed({1'b0, r_c2.qb});
        n_c3.pyb = r_c2.ny * $signed({1'b0, r_c2.qb});
        n_c3.vpx = diff33(r_c2.pair.vel_a[63:32], r_c2.pair.vel_b[63:32]) * r_c2.nx;
        n_c3.vpy = diff33(r_c2.pair.vel_a[31:0], r_c2.pair.vel_b[31:0]) * r_c2.ny;
    end

    // P4: separated positions, approach test, closing speed
    always_comb begin
        n_c4 = r_c3;
        n_c4.npa = {sat32(sx64(r_c3.pair.pos_a[63:32]) + rnd14(64'(r_c3.pxa))),
                    sat32(sx64(r_c3.pair.pos_a[31:0]) + rnd14(64'(r_c3.pya)))};
        n_c4.npb = {sat32(sx64(r_c3.pair.pos_b[63:32]) - rnd14(64'(r_c3.pxb))),
                    sat32(sx64(r_c3.pair.pos_b[31:0]) - rnd14(64'(r_c3.pyb)))};
        w_vn          = 50'(r_c3.vpx) + 50'(r_c3.vpy);
        n_c4.approach = w_vn[49] || (w_vn == '0);
        w_nvn         = -51'(w_vn);
        n_c4.m        = 36'((w_nvn + 51'sd8192) >>> NRM_FRAC);
    end

    // P5: restitution scale times closing speed
    always_comb begin
        n_c5       = r_c4;
        w_e        = 17'((18'(r_c4.pair.bounce_a) + 18'(r_c4.pair.bounce_b)) >> 1);
        n_c5.wprod = 54'(18'd65536 + 18'(w_e)) * 54'(r_c4.m);
    end

    // P6: impulse split by body share
    always_comb begin
        n_c6        = r_c5;
        w_w         = 39'((55'(r_c5.wprod) + 55'd32768) >> 16);
        n_c6.gaprod = 64'(w_w) * 64'(r_c5.fa);
        n_c6.gbprod = 64'(w_w) * 64'(r_c5.fb);
    end

    // P7: velocity change products
    always_comb begin
        n_c7     = r_c6;
        w_ga     = 40'(r_c6.gaprod >> SHARE_FRAC);
        w_gb     = 40'(r_c6.gbprod >> SHARE_FRAC);
        n_c7.vxa = r_c6.nx * $signed({1'b0, w_ga});
        n_c7.vya = r_c6.ny * $signed({1'b0, w_ga});
        n_c7.vxb = r_c6.nx * $signed({1'b0, w_gb});
        n_c7.vyb = r_c6.ny * $signed({1'b0, w_gb});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv2 <= 1'b0;
            r_pv3 <= 1'b0;
            r_pv4 <= 1'b0;
            r_pv5 <= 1'b0;
            r_pv6 <= 1'b0;
            r_pv7 <= 1'b0;
        end else if (w_en) begin
            r_pv2 <= w_vc1d;
            r_pv3 <= r_pv2;
            r_pv4 <= r_pv3;
            r_pv5 <= r_pv4;
            r_pv6 <= r_pv5;
            r_pv7 <= r_pv6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2 <= n_c2;
            r_c3 <= n_c3;
            r_c4 <= n_c4;
            r_c5 <= n_c5;
            r_c6 <= n_c6;
            r_c7 <= n_c7;
        end
    end

    // ---------------- result assembly into the output buffer
    t_result          w_res;
    logic             w_moves;
    logic [RES_W-1:0] w_out;
    t_result          w_out_s;

    always_comb begin
        // no mass in the pair: contact is reported but nothing moves
        w_moves              = r_c7.hit && r_c7.has_mass;
        w_res.contact_hit    = r_c7.hit;
        w_res.impulse_applied = w_moves && r_c7.approach;
        w_res.depth          = r_c7.hit ? $signed({1'b0, r_c7.dep}) : '0;
        w_res.contact_normal = r_c7.hit ? {r_c7.nx, r_c7.ny} : '0;
        w_res.new_pos_a      = w_moves ? r_c7.npa : r_c7.pair.pos_a;
        w_res.new_pos_b      = w_moves ? r_c7.npb : r_c7.pair.pos_b;
        if (w_moves && r_c7.approach) begin
            w_res.new_vel_a = {sat32(sx64(r_c7.pair.vel_a[63:32]) + rnd14(64'(r_c7.vxa))),
                               sat32(sx64(r_c7.pair.vel_a[31:0]) + rnd14(64'(r_c7.vya)))};
            w_res.new_vel_b = {sat32(sx64(r_c7.pair.vel_b[63:32]) - rnd14(64'(r_c7.vxb))),
                               sat32(sx64(r_c7.pair.vel_b[31:0]) - rnd14(64'(r_c7.vyb)))};
        end else begin
            w_res.new_vel_a = r_c7.pair.vel_a;
            w_res.new_vel_b = r_c7.pair.vel_b;
        end
    end

    ccr_skid #(.W(RES_W)) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_pv7 && w_en),
        .i_data  (w_res),
        .o_space (w_space),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_data  (w_out)
    );

    assign w_out_s                  = w_out;
    assign o_result.contact_hit     = w_out_s.contact_hit;
    assign o_result.impulse_applied = w_out_s.impulse_applied;
    assign o_result.depth           = w_out_s.depth;
    assign o_result.contact_normal  = w_out_s.contact_normal;
    assign o_result.new_pos_a       = w_out_s.new_pos_a;
    assign o_result.new_pos_b       = w_out_s.new_pos_b;
    assign o_result.new_vel_a       = w_out_s.new_vel_a;
    assign o_result.new_vel_b       = w_out_s.new_vel_b;
endmodule
